/* hdl/mcbd_pkg.sv */
// ----------------------------------------------------------------------------
// mcbd_pkg
// Shared widths, register indexes and payload types of the mip chain.
// ----------------------------------------------------------------------------
package mcbd_pkg;

	localparam int PIX_W       = 8;
	localparam int POS_W       = 11;
	localparam int LEVEL_W     = 4;
	localparam int CFG_DATA_W  = 13;
	localparam int CFG_INDEX_W = 8;
	localparam int RESET_DIM   = 256;

	localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 8'd1;

	typedef struct packed {
		logic [PIX_W-1:0] r;
		logic [PIX_W-1:0] g;
		logic [PIX_W-1:0] b;
		logic [PIX_W-1:0] a;
	} pix_t;

	typedef struct packed {
		logic [PIX_W:0] r;
		logic [PIX_W:0] g;
		logic [PIX_W:0] b;
		logic [PIX_W:0] a;
	} pair_t;

	typedef struct packed {
		logic             valid;
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		pix_t             pix;
	} tok_t;

endpackage

/* hdl/mcbd_if.sv */
// ----------------------------------------------------------------------------
// mcbd_if
// Handshake channels of the mip chain: pixels in, mip pixels out, config.
// ----------------------------------------------------------------------------
interface mcbd_pix_if;
	logic                         valid;
	logic                         ready;
	logic [mcbd_pkg::PIX_W-1:0]   red_in;
	logic [mcbd_pkg::PIX_W-1:0]   green_in;
	logic [mcbd_pkg::PIX_W-1:0]   blue_in;
	logic [mcbd_pkg::PIX_W-1:0]   alpha_in;

	modport source (output valid, output red_in, output green_in, output blue_in,
		output alpha_in, input ready);
	modport sink (input valid, input red_in, input green_in, input blue_in,
		input alpha_in, output ready);
endinterface

interface mcbd_mip_if;
	logic                         valid;
	logic                         ready;
	logic [mcbd_pkg::LEVEL_W-1:0] mip_level;
	logic [mcbd_pkg::POS_W-1:0]   pos_x;
	logic [mcbd_pkg::POS_W-1:0]   pos_y;
	logic [mcbd_pkg::PIX_W-1:0]   red_out;
	logic [mcbd_pkg::PIX_W-1:0]   green_out;
	logic [mcbd_pkg::PIX_W-1:0]   blue_out;
	logic [mcbd_pkg::PIX_W-1:0]   alpha_out;
	logic                         last_of_run;

	modport source (output valid, output mip_level, output pos_x, output pos_y,
		output red_out, output green_out, output blue_out, output alpha_out,
		output last_of_run, input ready);
	modport sink (input valid, input mip_level, input pos_x, input pos_y,
		input red_out, input green_out, input blue_out, input alpha_out,
		input last_of_run, output ready);
endinterface

interface mcbd_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [mcbd_pkg::CFG_INDEX_W-1:0] index;
	logic [mcbd_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* hdl/mcbd_cell.sv */
// ----------------------------------------------------------------------------
// mcbd_cell
// One level of the cascade: pairs pixels of its level into 2x2 blocks and
// hands the averaged pixel of the next level to its neighbor.
// ----------------------------------------------------------------------------
module mcbd_cell #(
	parameter int MAX_DIM = 4096,
	parameter int LEVEL   = 0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         restart,
	input  logic [$clog2(MAX_DIM+1)-1:0] width,
	input  logic [$clog2(MAX_DIM+1)-1:0] height,
	input  logic                         fire,
	input  mcbd_pkg::pix_t               pix,
	output logic                         emit,
	input  logic                         drain,
	output mcbd_pkg::tok_t               tok
);

	localparam int DIM_W   = $clog2(MAX_DIM + 1);
	localparam int LVL_DIM = ((MAX_DIM >> LEVEL) < 2) ? 2 : (MAX_DIM >> LEVEL);
	localparam int CW      = $clog2(LVL_DIM);
	localparam int DEPTH   = ((MAX_DIM >> (LEVEL + 1)) < 2) ? 2 : (MAX_DIM >> (LEVEL + 1));
	localparam int AW      = $clog2(DEPTH);

	logic [CW-1:0]    x_q, y_q, x_d, y_d;
	logic [DIM_W-1:0] lvl_w, lvl_h, even_w, even_h;
	logic             lvl_ok, active, x_last, y_last, row_we;
	mcbd_pkg::pix_t   held_q, avg;
	mcbd_pkg::pair_t  pair, rd_q;
	mcbd_pkg::pair_t  row_mem [DEPTH];
	logic [mcbd_pkg::PIX_W+1:0] sum_r, sum_g, sum_b, sum_a;
	logic             tok_valid_q;
	logic [mcbd_pkg::POS_W-1:0] tok_x_q, tok_y_q;
	mcbd_pkg::pix_t   tok_pix_q;

	assign lvl_w  = width >> LEVEL;
	assign lvl_h  = height >> LEVEL;
	assign even_w = (width >> (LEVEL + 1)) << 1;
	assign even_h = (height >> (LEVEL + 1)) << 1;

	assign lvl_ok = (even_w != '0) && (even_h != '0);
	assign active = lvl_ok && (DIM_W'(x_q) < even_w) && (DIM_W'(y_q) < even_h);
	assign emit   = active && x_q[0] && y_q[0];
	assign row_we = fire && active && x_q[0] && !y_q[0];

	assign x_last = (DIM_W'(x_q) + DIM_W'(1)) >= lvl_w;
	assign y_last = (DIM_W'(y_q) + DIM_W'(1)) >= lvl_h;

	always_comb begin
		x_d = x_q;
		y_d = y_q;
		if (restart) begin
			x_d = '0;
			y_d = '0;
		end else if (fire) begin
			if (x_last) begin
				x_d = '0;
				y_d = y_last ? '0 : y_q + CW'(1);
			end else begin
				x_d = x_q + CW'(1);
			end
		end
	end

	always_comb begin
		pair.r = {1'b0, held_q.r} + {1'b0, pix.r};
		pair.g = {1'b0, held_q.g} + {1'b0, pix.g};
		pair.b = {1'b0, held_q.b} + {1'b0, pix.b};
		pair.a = {1'b0, held_q.a} + {1'b0, pix.a};
		sum_r  = {1'b0, rd_q.r} + {1'b0, pair.r};
		sum_g  = {1'b0, rd_q.g} + {1'b0, pair.g};
		sum_b  = {1'b0, rd_q.b} + {1'b0, pair.b};
		sum_a  = {1'b0, rd_q.a} + {1'b0, pair.a};
		avg.r  = sum_r[mcbd_pkg::PIX_W+1:2];
		avg.g  = sum_g[mcbd_pkg::PIX_W+1:2];
		avg.b  = sum_b[mcbd_pkg::PIX_W+1:2];
		avg.a  = sum_a[mcbd_pkg::PIX_W+1:2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
		end else begin
			x_q <= x_d;
			y_q <= y_d;
		end
	end

	// The read address follows the next column count, so the pair sum of
	// the row above is ready when the pixel that needs it arrives.
	always_ff @(posedge clk) begin
		if (row_we) begin
			row_mem[AW'(x_q >> 1)] <= pair;
		end
		rd_q <= row_mem[AW'(x_d >> 1)];
	end

	always_ff @(posedge clk) begin
		if (fire && active && !x_q[0]) begin
			held_q <= pix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else if (fire && emit) begin
			tok_valid_q <= 1'b1;
		end else if (drain) begin
			tok_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			tok_x_q   <= mcbd_pkg::POS_W'(x_q >> 1);
			tok_y_q   <= mcbd_pkg::POS_W'(y_q >> 1);
			tok_pix_q <= avg;
		end
	end

	assign tok.valid = tok_valid_q;
	assign tok.x     = tok_x_q;
	assign tok.y     = tok_y_q;
	assign tok.pix   = tok_pix_q;

endmodule

/* hdl/mcbd_pick.sv */
// ----------------------------------------------------------------------------
// mcbd_pick
// Result selector: presents the deepest waiting level pixel, which is always
// the oldest, and retires it on a transfer.
// ----------------------------------------------------------------------------
module mcbd_pick #(
	parameter int LEVELS = 12
) (
	input  mcbd_pkg::tok_t    tok [LEVELS],
	input  logic [LEVELS-1:0] emit,
	output logic [LEVELS-1:0] drain,
	mcbd_mip_if.source        mip
);

	logic [LEVELS-1:0]            hot;
	logic [LEVELS-1:0]            nxt_emit;
	mcbd_pkg::tok_t               pick;
	logic [mcbd_pkg::LEVEL_W-1:0] lvl;
	logic                         last;

	assign nxt_emit = emit >> 1;

	always_comb begin
		hot  = '0;
		pick = '0;
		lvl  = '0;
		last = 1'b0;
		for (int i = 0; i < LEVELS; i++) begin
			if (tok[i].valid) begin
				hot    = '0;
				hot[i] = 1'b1;
				pick   = tok[i];
				lvl    = mcbd_pkg::LEVEL_W'(i + 1);
				last   = !nxt_emit[i];
			end
		end
	end

	assign drain           = hot & {LEVELS{mip.ready}};
	assign mip.valid       = |hot;
	assign mip.mip_level   = lvl;
	assign mip.pos_x       = pick.x;
	assign mip.pos_y       = pick.y;
	assign mip.red_out     = pick.pix.r;
	assign mip.green_out   = pick.pix.g;
	assign mip.blue_out    = pick.pix.b;
	assign mip.alpha_out   = pick.pix.a;
	assign mip.last_of_run = last;

endmodule

/* hdl/mip_chain_box_downsample.sv */
// ----------------------------------------------------------------------------
// mip_chain_box_downsample
// Streams level-zero RGBA pixels through a chain of level cells and emits
// every coarser mip level pixel, tagged with its level and position.
// ----------------------------------------------------------------------------
//  channel  modport  carries
//  pixel    sink     one level-zero pixel per transfer, raster order
//  mip      source   one generated pixel with level, position, last_of_run
//  cfg      sink     register index and data, always ready
//
// A pixel can be taken every cycle; its level-one result is registered at the
// transfer edge; each further level is registered as the one above goes out.
// Results left from an earlier run go out first. A pixel stalls only when it
// would finish a level-one pixel while that register is full and not emptied
// in the same cycle. Reset clears counts and valid flags; the row stores need
// no clearing pass, and a width or height write restarts the frame.
// ----------------------------------------------------------------------------
module mip_chain_box_downsample #(
	parameter int MAX_DIM    = 4096,
	parameter int MAX_LEVELS = 12
) (
	input logic        clk,
	input logic        arst_n,
	mcbd_pix_if.sink   pixel,
	mcbd_mip_if.source mip,
	mcbd_cfg_if.sink   cfg
);

	localparam int DIM_W     = $clog2(MAX_DIM + 1);
	localparam int RESET_DIM = (mcbd_pkg::RESET_DIM > MAX_DIM) ? MAX_DIM : mcbd_pkg::RESET_DIM;

	logic [DIM_W-1:0]      width_q, height_q;
	logic                  cfg_fire, restart;
	mcbd_pkg::tok_t        tok [MAX_LEVELS];
	logic [MAX_LEVELS-1:0] emit, drain, fire;
	mcbd_pkg::pix_t        in_pix;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [mcbd_pkg::CFG_DATA_W-1:0] v);
		if (v == '0) begin
			return DIM_W'(1);
		end
		if (32'(v) > MAX_DIM) begin
			return DIM_W'(MAX_DIM);
		end
		return DIM_W'(v);
	endfunction

	assign cfg.ready = 1'b1;
	assign cfg_fire  = cfg.valid && cfg.ready;
	assign restart   = cfg_fire && ((cfg.index == mcbd_pkg::CFG_IMAGE_WIDTH) ||
		(cfg.index == mcbd_pkg::CFG_IMAGE_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(RESET_DIM);
			height_q <= DIM_W'(RESET_DIM);
		end else if (cfg_fire) begin
			unique case (cfg.index)
				mcbd_pkg::CFG_IMAGE_WIDTH: begin
					width_q <= clamp_dim(cfg.data);
				end
				mcbd_pkg::CFG_IMAGE_HEIGHT: begin
					height_q <= clamp_dim(cfg.data);
				end
				default: begin
				end
			endcase
		end
	end

	assign in_pix.r = pixel.red_in;
	assign in_pix.g = pixel.green_in;
	assign in_pix.b = pixel.blue_in;
	assign in_pix.a = pixel.alpha_in;

	assign pixel.ready = !emit[0] || !tok[0].valid || drain[0];
	assign fire[0]     = pixel.valid && pixel.ready;

	for (genvar i = 0; i < MAX_LEVELS; i++) begin : g_cell
		if (i > 0) begin : g_link
			assign fire[i] = drain[i-1];
		end
		mcbd_cell #(
			.MAX_DIM (MAX_DIM),
			.LEVEL   (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.restart (restart),
			.width   (width_q),
			.height  (height_q),
			.fire    (fire[i]),
			.pix     ((i == 0) ? in_pix : tok[(i == 0) ? 0 : i - 1].pix),
			.emit    (emit[i]),
			.drain   (drain[i]),
			.tok     (tok[i])
		);
	end

	mcbd_pick #(
		.LEVELS (MAX_LEVELS)
	) u_pick (
		.tok   (tok),
		.emit  (emit),
		.drain (drain),
		.mip   (mip)
	);

`ifndef SYNTHESIS
	// A result that is not the last of its run is followed at once by the
	// next level.
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(mip.valid && mip.ready && !mip.last_of_run) |=>
		(mip.valid && (mip.mip_level == $past(mip.mip_level) + 4'd1)))
		else $error("run of mip results broken");

	// Every result lies inside the dimensions of its level.
	a_pos_in_level: assert property (@(posedge clk) disable iff (!arst_n)
		mip.valid |-> ((32'(mip.pos_x) < (32'(width_q) >> mip.mip_level)) &&
		(32'(mip.pos_y) < (32'(height_q) >> mip.mip_level))))
		else $error("mip result outside its level");

	// The pixel input holds off only while a result is waiting.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel.valid && !pixel.ready) |-> mip.valid)
		else $error("pixel input stalled with no result pending");
`endif

endmodule
